// ===== rtl/sda_pkg.sv =====
// shared types and constants for the scaled decimal arithmetic unit
// no dependencies; used by sda_addsub and scaled_decimal_alu
`default_nettype none

package sda_pkg;

    // mantissa and exponent widths fixed by the operand format
    localparam int unsigned MANT_W = 64;
    localparam int unsigned EXP_IN_W = 8;
    localparam int unsigned EXP_OUT_W = 10;
    // the shared adder is one bit wider for the divide trial subtract
    localparam int unsigned ADD_W = MANT_W + 1;

    // operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    // request to the shared adder
    typedef struct packed {
        logic [ADD_W-1:0] x;
        logic [ADD_W-1:0] y;
        logic             sub;
    } add_req_t;

    // answer from the shared adder
    typedef struct packed {
        logic [ADD_W-1:0] sum;
        logic             carry;
    } add_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sda_addsub.sv =====
// shared 65-bit adder/subtractor used for every arithmetic step
// depends on sda_pkg for the request and answer structs
`default_nettype none

module sda_addsub (
    input  wire sda_pkg::add_req_t req,
    output sda_pkg::add_rsp_t rsp
);

    logic [sda_pkg::ADD_W-1:0] y_eff;
    logic [sda_pkg::ADD_W:0]   total;

    // two's complement subtract by inverting and carrying in
    always_comb
    begin
        y_eff = req.sub ? ~req.y : req.y;
        total = {1'b0, req.x} + {1'b0, y_eff} + {{sda_pkg::ADD_W{1'b0}}, req.sub};
        rsp.sum = total[sda_pkg::ADD_W-1:0];
        rsp.carry = total[sda_pkg::ADD_W];
    end

endmodule

`default_nettype wire

// ===== rtl/scaled_decimal_alu.sv =====
// channel   | signals                                              | direction
// ----------+------------------------------------------------------+----------
// request   | in_valid, in_ready, op, left_/right_mantissa/exponent | in
// result    | out_valid, out_ready, result_mantissa/_exponent,      | out
//           | divide_by_zero                                       |
//
// one request at a time through a single shared 65-bit adder under a sequencer
// add/sub: the larger-exponent operand is scaled by ten per exponent step, at most 64 steps
// multiply: one shift-and-add per multiplier bit
// divide: up to DIV_EXTRA_DIGITS scaling steps, then a 64-step restoring divide
// with sign handling; a zero divisor goes straight to the finish state
// asynchronous active-low reset returns to idle; a held result stalls only
// the final hand-over into the output register
// depends on sda_pkg and sda_addsub
`default_nettype none

module scaled_decimal_alu #(
    parameter int unsigned DIV_EXTRA_DIGITS = 5
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [1:0]                          op,
    input  wire  signed [sda_pkg::MANT_W-1:0]   left_mantissa,
    input  wire  signed [sda_pkg::EXP_IN_W-1:0] left_exponent,
    input  wire  signed [sda_pkg::MANT_W-1:0]   right_mantissa,
    input  wire  signed [sda_pkg::EXP_IN_W-1:0] right_exponent,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [sda_pkg::MANT_W-1:0]   result_mantissa,
    output logic signed [sda_pkg::EXP_OUT_W-1:0] result_exponent,
    output logic                                divide_by_zero
);

    localparam int unsigned MW = sda_pkg::MANT_W;
    localparam int unsigned EW = sda_pkg::EXP_OUT_W;
    localparam int unsigned CNT_W = 7;
    // beyond 64 steps of times ten the mantissa is zero modulo two to 64
    localparam logic [CNT_W-1:0] ALIGN_MAX = CNT_W'(MW);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_EXTRA_DIGITS);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_ALIGN_L   = 11'b000_0000_0010,
        ST_ALIGN_R   = 11'b000_0000_0100,
        ST_ADDSUB    = 11'b000_0000_1000,
        ST_MUL       = 11'b000_0001_0000,
        ST_DIV_SCALE = 11'b000_0010_0000,
        ST_DIV_ABS_A = 11'b000_0100_0000,
        ST_DIV_ABS_B = 11'b000_1000_0000,
        ST_DIV_RUN   = 11'b001_0000_0000,
        ST_DIV_SIGN  = 11'b010_0000_0000,
        ST_FINISH    = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [MW-1:0]      a_reg, a_next;
    logic [MW-1:0]      b_reg, b_next;
    logic [MW-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [EW-1:0] exp_reg, exp_next;
    sda_pkg::op_t       op_reg, op_next;
    logic               na_reg, na_next;
    logic               nb_reg, nb_next;
    logic               dz_reg, dz_next;
    logic [MW-1:0]      res_mant_reg, res_mant_next;
    logic signed [EW-1:0] res_exp_reg, res_exp_next;
    logic               res_dz_reg, res_dz_next;

    sda_pkg::add_req_t  add_req;
    sda_pkg::add_rsp_t  add_rsp;

    logic signed [EW-1:0] le_x, re_x, gap;
    logic [EW-1:0]        gap_mag;
    logic [CNT_W-1:0]     align_cnt;
    logic                 in_fire, hand_over;

    sda_addsub u_addsub (
        .req (add_req),
        .rsp (add_rsp)
    );

    // exponent gap and the capped number of times-ten steps
    always_comb
    begin
        le_x = EW'(left_exponent);
        re_x = EW'(right_exponent);
        gap = le_x - re_x;
        gap_mag = gap[EW-1] ? (EW'(0) - gap) : gap;
        align_cnt = (gap_mag > EW'(ALIGN_MAX)) ? ALIGN_MAX : gap_mag[CNT_W-1:0];
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign hand_over = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // operand selection for the shared adder
    always_comb
    begin
        add_req = '0;
        case (state_reg)
            ST_ALIGN_L, ST_DIV_SCALE:
            begin
                add_req.x = {1'b0, a_reg[MW-4:0], 3'b000};
                add_req.y = {1'b0, a_reg[MW-2:0], 1'b0};
            end
            ST_ALIGN_R:
            begin
                add_req.x = {1'b0, b_reg[MW-4:0], 3'b000};
                add_req.y = {1'b0, b_reg[MW-2:0], 1'b0};
            end
            ST_ADDSUB:
            begin
                add_req.x = {1'b0, a_reg};
                add_req.y = {1'b0, b_reg};
                add_req.sub = (op_reg == sda_pkg::OP_SUB);
            end
            ST_MUL:
            begin
                add_req.x = {1'b0, acc_reg};
                add_req.y = {1'b0, a_reg};
            end
            ST_DIV_ABS_A, ST_DIV_SIGN:
            begin
                add_req.y = {1'b0, a_reg};
                add_req.sub = 1'b1;
            end
            ST_DIV_ABS_B:
            begin
                add_req.y = {1'b0, b_reg};
                add_req.sub = 1'b1;
            end
            ST_DIV_RUN:
            begin
                add_req.x = {acc_reg, a_reg[MW-1]};
                add_req.y = {1'b0, b_reg};
                add_req.sub = 1'b1;
            end
            default:
            begin
                add_req = '0;
            end
        endcase
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        op_next = op_reg;
        na_next = na_reg;
        nb_next = nb_reg;
        dz_next = dz_reg;
        res_mant_next = res_mant_reg;
        res_exp_next = res_exp_reg;
        res_dz_next = res_dz_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    a_next = left_mantissa;
                    b_next = right_mantissa;
                    acc_next = '0;
                    op_next = op;
                    dz_next = 1'b0;
                    nb_next = right_mantissa[MW-1];
                    case (op)
                        sda_pkg::OP_ADD, sda_pkg::OP_SUB:
                        begin
                            cnt_next = align_cnt;
                            if (gap > 0)
                            begin
                                exp_next = re_x;
                                state_next = ST_ALIGN_L;
                            end
                            else if (gap < 0)
                            begin
                                exp_next = le_x;
                                state_next = ST_ALIGN_R;
                            end
                            else
                            begin
                                exp_next = le_x;
                                state_next = ST_ADDSUB;
                            end
                        end
                        sda_pkg::OP_MUL:
                        begin
                            exp_next = le_x + re_x;
                            cnt_next = ALIGN_MAX;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            cnt_next = DIV_STEPS;
                            if (gap < $signed(EW'(DIV_EXTRA_DIGITS)))
                            begin
                                exp_next = gap - $signed(EW'(DIV_EXTRA_DIGITS));
                            end
                            else
                            begin
                                exp_next = gap;
                            end
                            if (right_mantissa == '0)
                            begin
                                dz_next = 1'b1;
                                a_next = '0;
                                state_next = ST_FINISH;
                            end
                            else if ((gap < $signed(EW'(DIV_EXTRA_DIGITS)))
                                     && (DIV_STEPS != '0))
                            begin
                                state_next = ST_DIV_SCALE;
                            end
                            else
                            begin
                                state_next = ST_DIV_ABS_A;
                            end
                        end
                    endcase
                end
            end
            ST_ALIGN_L:
            begin
                a_next = add_rsp.sum[MW-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_ADDSUB;
                end
            end
            ST_ALIGN_R:
            begin
                b_next = add_rsp.sum[MW-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_ADDSUB;
                end
            end
            ST_ADDSUB:
            begin
                a_next = add_rsp.sum[MW-1:0];
                state_next = ST_FINISH;
            end
            ST_MUL:
            begin
                // shift-and-add over the multiplier bits
                if (b_reg[0])
                begin
                    acc_next = add_rsp.sum[MW-1:0];
                end
                a_next = {a_reg[MW-2:0], 1'b0};
                b_next = {1'b0, b_reg[MW-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    a_next = b_reg[0] ? add_rsp.sum[MW-1:0] : acc_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_DIV_SCALE:
            begin
                a_next = add_rsp.sum[MW-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DIV_ABS_A;
                end
            end
            ST_DIV_ABS_A:
            begin
                // sign of the scaled dividend, with the divisor sign, decides the quotient sign
                na_next = a_reg[MW-1];
                if (a_reg[MW-1])
                begin
                    a_next = add_rsp.sum[MW-1:0];
                end
                state_next = ST_DIV_ABS_B;
            end
            ST_DIV_ABS_B:
            begin
                if (nb_reg)
                begin
                    b_next = add_rsp.sum[MW-1:0];
                end
                acc_next = '0;
                cnt_next = ALIGN_MAX;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                // restoring step: remainder in acc, quotient shifts into a
                acc_next = add_rsp.carry ? add_rsp.sum[MW-1:0]
                                         : {acc_reg[MW-2:0], a_reg[MW-1]};
                a_next = {a_reg[MW-2:0], add_rsp.carry};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DIV_SIGN;
                end
            end
            ST_DIV_SIGN:
            begin
                if (na_reg != nb_reg)
                begin
                    a_next = add_rsp.sum[MW-1:0];
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (hand_over)
                begin
                    res_mant_next = a_reg;
                    res_exp_next = exp_reg;
                    res_dz_next = dz_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        exp_reg <= exp_next;
        op_reg <= op_next;
        na_reg <= na_next;
        nb_reg <= nb_next;
        dz_reg <= dz_next;
        res_mant_reg <= res_mant_next;
        res_exp_reg <= res_exp_next;
        res_dz_reg <= res_dz_next;
    end

    assign out_valid = out_valid_reg;
    assign result_mantissa = res_mant_reg;
    assign result_exponent = res_exp_reg;
    assign divide_by_zero = res_dz_reg;

endmodule

`default_nettype wire
